@@ hw/rtl/lrrq_pkg.sv @@
// ----------------------------------------------------------------------------
// Ready queue package
// Sizes, codes, entry layout and the modulo unit's interface.
// ----------------------------------------------------------------------------
package lrrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int TK_W        = 8;
  localparam int RND_W       = 31;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OFF_W       = IDX_W + 1;
  localparam int TOT_W       = $clog2(QUEUE_DEPTH * ((1 << TK_W) - 1) + 1);
  localparam int STEP_W      = $clog2(RND_W + 1);

  localparam logic ACT_ENQ   = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RR   = 2'd0,
    MODE_LOT  = 2'd1,
    MODE_FCFS = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOTICKETS = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TK_W-1:0] tk;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TOT_W-1:0] rem;
  } div_resp_t;

  // b stays below QUEUE_DEPTH, so one subtraction wraps the sum
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(QUEUE_DEPTH)) s = s - (IDX_W + 1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/lrrq_mod.sv @@
// ----------------------------------------------------------------------------
// Lottery draw modulo unit
// Restoring remainder, one dividend bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module lrrq_mod (
  input  logic                clk,
  input  logic                rst,
  input  lrrq_pkg::div_req_t  req,
  output lrrq_pkg::div_resp_t resp
);
  import lrrq_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [RND_W-1:0]  dvd;
  logic [TOT_W-1:0]  dvs;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  rem_next;
  logic [TOT_W:0]    rem_sh;

  always_comb begin
    rem_sh = {rem, dvd[RND_W-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = TOT_W'(rem_sh - {1'b0, dvs});
    end else begin
      rem_next = rem_sh[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[RND_W-2:0], 1'b0};
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.rem  = rem;

endmodule

@@ hw/rtl/lottery_round_robin_ready_queue_top.sv @@
// ----------------------------------------------------------------------------
// Lottery / round robin ready queue
// Circular task queue in one memory, scheduled by round robin, lottery or peek.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next is taken while a result waits in
// the output register. An enqueue, or a schedule on an empty queue or in the
// unused mode, goes straight to the response state; a round robin or first
// come first served schedule reads the head entry first, and a lottery whose
// tickets total zero stops after totalling them. A lottery over n entries
// totals their tickets through the single memory read port, runs the
// bit-serial modulo, then walks to the winner and shifts the entries behind
// it, each one entry a cycle.
// Queue storage needs no clearing after reset.
module lottery_round_robin_ready_queue_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        action,
  input  logic [lrrq_pkg::ID_W-1:0]   task_id,
  input  logic [lrrq_pkg::TK_W-1:0]   tickets,
  input  logic [lrrq_pkg::RND_W-1:0]  random_value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [lrrq_pkg::STAT_W-1:0] status,
  output logic [lrrq_pkg::ID_W-1:0]   chosen_id,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lrrq_pkg::MODE_W-1:0] cfg_data
);
  import lrrq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HEAD  = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_SHIFT = 8'b0010_0000,
    S_PLACE = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  entry_t           mem [QUEUE_DEPTH];
  entry_t           rdata;
  logic             rd_en;
  logic [OFF_W-1:0] rd_off;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  state_t           state, state_next;
  mode_t            mode;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] r, r_next;
  logic [TOT_W-1:0] total, total_next;
  logic [TOT_W-1:0] sum, sum_next;
  logic [TOT_W-1:0] draw, draw_next;
  logic [RND_W-1:0] rnd, rnd_next;
  entry_t           win, win_next;
  status_t          res_status, res_status_next;
  logic [ID_W-1:0]  res_id, res_id_next;

  logic [OFF_W-1:0] r_p1;
  logic [OFF_W-1:0] r_p2;
  logic [OFF_W-1:0] count_x;
  logic [TOT_W-1:0] acc_tk;
  logic [TOT_W-1:0] total_n;
  logic [TOT_W-1:0] sum_n;
  logic [CNT_W-1:0] count_m1;
  logic             out_free;

  div_req_t         div_req;
  div_resp_t        div_resp;

  lrrq_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;

  assign r_p1     = OFF_W'(r) + OFF_W'(1);
  assign r_p2     = OFF_W'(r) + OFF_W'(2);
  assign count_x  = OFF_W'(count);
  assign count_m1 = count - CNT_W'(1);
  assign acc_tk   = TOT_W'(rdata.tk);
  assign total_n  = total + acc_tk;
  assign sum_n    = sum + acc_tk;
  assign rd_addr  = wrap_add(head, rd_off[IDX_W-1:0]);

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    r_next           = r;
    total_next       = total;
    sum_next         = sum;
    draw_next        = draw;
    rnd_next         = rnd;
    win_next         = win;
    res_status_next  = res_status;
    res_id_next      = res_id;
    rd_en            = 1'b0;
    rd_off           = '0;
    wr_en            = 1'b0;
    wr_addr          = head;
    wr_data          = '{id: task_id, tk: tickets};
    div_req.start    = 1'b0;
    div_req.dividend = rnd;
    div_req.divisor  = total_n;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          rnd_next        = random_value;
          res_id_next     = '0;
          res_status_next = ST_OK;
          state_next      = S_RESP;
          if (action == ACT_ENQ) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = wrap_add(head, count[IDX_W-1:0]);
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0 || mode == MODE_NONE) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
            if (mode == MODE_LOT) begin
              r_next     = '0;
              total_next = '0;
              state_next = S_SUM;
            end else begin
              state_next = S_HEAD;
            end
          end
        end
      end
      S_HEAD: begin
        res_id_next = rdata.id;
        if (mode == MODE_RR) begin
          head_next  = wrap_add(head, IDX_W'(1));
          count_next = count_m1;
        end
        state_next = S_RESP;
      end
      S_SUM: begin
        total_next = total_n;
        rd_off     = r_p1;
        rd_en      = (r_p1 < count_x);
        if (r_p1 == count_x) begin
          if (total_n == '0) begin
            res_status_next = ST_NOTICKETS;
            state_next      = S_RESP;
          end else begin
            div_req.start = 1'b1;
            state_next    = S_MOD;
          end
        end else begin
          r_next = r_p1[IDX_W-1:0];
        end
      end
      S_MOD: begin
        if (div_resp.done) begin
          draw_next  = div_resp.rem;
          sum_next   = '0;
          r_next     = '0;
          rd_en      = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        sum_next = sum_n;
        rd_off   = r_p1;
        rd_en    = (r_p1 < count_x);
        if (sum_n > draw) begin
          win_next   = rdata;
          state_next = (r_p1 == count_x) ? S_PLACE : S_SHIFT;
        end else begin
          r_next = r_p1[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head, r);
        wr_data = rdata;
        if (r_p2 == count_x) begin
          state_next = S_PLACE;
        end else begin
          rd_en  = 1'b1;
          rd_off = r_p2;
          r_next = r_p1[IDX_W-1:0];
        end
      end
      S_PLACE: begin
        wr_en       = 1'b1;
        wr_addr     = wrap_add(head, count_m1[IDX_W-1:0]);
        wr_data     = win;
        res_id_next = win.id;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= MODE_RR;
      head         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) mode <= mode_t'(cfg_data);
      if (state == S_RESP && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r          <= r_next;
    total      <= total_next;
    sum        <= sum_next;
    draw       <= draw_next;
    rnd        <= rnd_next;
    win        <= win_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    if (state == S_RESP && out_free) begin
      status    <= res_status;
      chosen_id <= res_id;
    end
  end

endmodule
